// ===== rtl/rbv_pkg.sv =====
`timescale 1ns / 1ps
package rbv_pkg;

  localparam int DataW     = 32;
  localparam int CompW     = 32;
  localparam int BlW       = $clog2(CompW + 1);
  localparam int NormW     = 30;
  localparam int SqrtSteps = 32;
  localparam int NormSteps = 31;
  localparam int QuotSteps = 34;
  localparam int NStage    = 5 + SqrtSteps + 1 + NormSteps + 1 + 6 + QuotSteps + 2;

  localparam logic signed [63:0] SinEpsSq = 64'sd115292151;
  localparam logic signed [63:0] OneQ60   = 64'sh1000_0000_0000_0000;
  localparam logic [63:0]        RndQ30   = 64'd536870912;
  localparam logic [33:0]        QuotCap  = 34'h2_0000_0000;
  localparam logic signed [36:0] OneQ30   = 37'sd1073741824;
  localparam logic signed [36:0] SatHi    = 37'sd2147483647;
  localparam logic signed [36:0] SatLo    = -37'sd2147483648;
  localparam logic signed [DataW-1:0] OneOut = 32'sh4000_0000;

  // per-vector side data through the front end
  typedef struct packed {
    logic [2:0][NormW-1:0] m;
    logic [2:0]            neg;
    logic                  nz;
  } vtag_t;

  // per-vector side data through the normalising divider
  typedef struct packed {
    logic [2:0]  neg;
    logic        nz;
    logic [61:0] dv;
  } ntag_t;

  // side data through the quotient divider
  typedef struct packed {
    logic [2:0][32:0] v;
    logic [5:0]       neg;
    logic [5:0]       big;
    logic             ok;
    logic [65:0]      dq;
  } qtag_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [36:0] e);
    if (e > SatHi) begin
      return 32'sh7FFF_FFFF;
    end else if (e < SatLo) begin
      return 32'sh8000_0000;
    end
    return e[31:0];
  endfunction

endpackage

// ===== rtl/rotation_between_two_vectors.sv =====
`timescale 1ns / 1ps
// Channel | Handshake          | Beat contents
// in      | in_valid/in_stall  | in_first_x/y/z, in_second_x/y/z (signed, shared scale)
// out     | out_valid/out_stall| out_r00..out_r22 (signed Q2.30), out_degenerate
//
// One beat per cycle in and one per cycle out while the output is not stalled; the
// pipeline holds the 32-step square root, the 31-step normalising divider and the
// 34-step quotient divider, one step per stage.
// Reset clears only the valid bits of the stages.
// A stall on the output freezes every stage, so nothing is dropped or repeated.
module rotation_between_two_vectors (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [rbv_pkg::DataW-1:0] in_first_x,
  input  logic signed [rbv_pkg::DataW-1:0] in_first_y,
  input  logic signed [rbv_pkg::DataW-1:0] in_first_z,
  input  logic signed [rbv_pkg::DataW-1:0] in_second_x,
  input  logic signed [rbv_pkg::DataW-1:0] in_second_y,
  input  logic signed [rbv_pkg::DataW-1:0] in_second_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [rbv_pkg::DataW-1:0] out_r00,
  output logic signed [rbv_pkg::DataW-1:0] out_r01,
  output logic signed [rbv_pkg::DataW-1:0] out_r02,
  output logic signed [rbv_pkg::DataW-1:0] out_r10,
  output logic signed [rbv_pkg::DataW-1:0] out_r11,
  output logic signed [rbv_pkg::DataW-1:0] out_r12,
  output logic signed [rbv_pkg::DataW-1:0] out_r20,
  output logic signed [rbv_pkg::DataW-1:0] out_r21,
  output logic signed [rbv_pkg::DataW-1:0] out_r22,
  output logic out_degenerate
);
  import rbv_pkg::*;

  logic              adv;
  logic [NStage-1:0] vld_r;
  logic [DataW-1:0]  vin [2][3];

  // front end
  logic [CompW-1:0]   mag0_nxt [2][3];
  logic [CompW-1:0]   mag0_r   [2][3];
  logic [2:0]         neg0_r   [2];
  logic [CompW-1:0]   or1      [2];
  logic [BlW-1:0]     bl1_nxt  [2];
  logic [CompW-1:0]   mag1_r   [2][3];
  logic [2:0]         neg1_r   [2];
  logic [BlW-1:0]     bl1_r    [2];
  logic [CompW+29:0]  ext2     [2][3];
  logic [CompW+29:0]  sh2      [2][3];
  vtag_t              tg2_nxt  [2];
  vtag_t              tg2_r    [2];
  logic [59:0]        p3_r     [2][3];
  vtag_t              tg3_r    [2];

  // square root
  logic [63:0]        xs_r     [2][0:SqrtSteps];
  logic [63:0]        rs_r     [2][0:SqrtSteps];
  vtag_t              tgs_r    [2][0:SqrtSteps];
  logic [63:0]        xs_nxt   [2][SqrtSteps];
  logic [63:0]        rs_nxt   [2][SqrtSteps];
  logic [63:0]        trial    [2][SqrtSteps];

  // normalising divider
  logic [30:0]        lenf     [2];
  logic [61:0]        remd_r   [2][3][0:NormSteps];
  logic [30:0]        qd_r     [2][3][0:NormSteps];
  ntag_t              ntg_r    [2][0:NormSteps];
  logic [62:0]        td       [2][3][NormSteps];
  logic [61:0]        remd_nxt [2][3][NormSteps];
  logic [30:0]        qd_nxt   [2][3][NormSteps];
  logic [31:0]        qe       [2][3];
  logic signed [31:0] u_r      [2][3];
  logic               oku_r;

  // cross, dot and K*K
  logic signed [63:0] p1_r     [9];
  logic               ok1_r;
  logic signed [63:0] diff2    [3];
  logic [63:0]        dmag2    [3];
  logic [63:0]        rsum2    [3];
  logic [32:0]        v2_nxt   [3];
  logic [32:0]        v2_r     [3];
  logic signed [63:0] d2_r;
  logic               ok2_r;
  logic signed [63:0] vv3_r    [6];
  logic [32:0]        v3_r     [3];
  logic signed [63:0] d3_r;
  logic               ok3_r;
  logic signed [63:0] s4_r;
  logic signed [63:0] vv4_r    [6];
  logic [32:0]        v4_r     [3];
  logic signed [63:0] d4_r;
  logic               ok4_r;
  logic signed [63:0] sq5      [6];
  logic [63:0]        nm5_r    [6];
  logic [5:0]         ng5_r;
  logic [65:0]        dq5_r;
  logic [32:0]        v5_r     [3];
  logic               ok5_r;
  qtag_t              qtg6_nxt;

  // quotient divider
  logic [65:0]        remq_r   [6][0:QuotSteps];
  logic [33:0]        qq_r     [6][0:QuotSteps];
  qtag_t              qtg_r    [0:QuotSteps];
  logic [66:0]        tq       [6][QuotSteps];
  logic [65:0]        remq_nxt [6][QuotSteps];
  logic [33:0]        qq_nxt   [6][QuotSteps];

  // output assembly
  logic [34:0]        qr1      [6];
  logic signed [34:0] qs_r     [6];
  logic [32:0]        vf_r     [3];
  logic               okf_r;
  logic signed [36:0] e_sum    [9];
  logic signed [DataW-1:0] res_nxt [9];
  logic signed [DataW-1:0] res_r   [9];
  logic               deg_r;

  assign adv      = !vld_r[NStage-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[NStage-1];

  assign vin[0][0] = in_first_x;
  assign vin[0][1] = in_first_y;
  assign vin[0][2] = in_first_z;
  assign vin[1][0] = in_second_x;
  assign vin[1][1] = in_second_y;
  assign vin[1][2] = in_second_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NStage-2:0], in_valid};
    end
  end

  // magnitudes, bit length of the largest, normalising shift
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      for (int i = 0; i < 3; i++) begin
        mag0_nxt[w][i] = vin[w][i][CompW-1] ? (~vin[w][i][CompW-1:0] + 1'b1)
                                            : vin[w][i][CompW-1:0];
      end
      or1[w] = mag0_r[w][0] | mag0_r[w][1] | mag0_r[w][2];
      bl1_nxt[w] = '0;
      for (int k = 0; k < CompW; k++) begin
        if (or1[w][k]) begin
          bl1_nxt[w] = BlW'(k + 1);
        end
      end
      for (int i = 0; i < 3; i++) begin
        ext2[w][i] = {30'b0, mag1_r[w][i]};
        if (bl1_r[w] > BlW'(NormW)) begin
          sh2[w][i] = ext2[w][i] >> (bl1_r[w] - BlW'(NormW));
        end else begin
          sh2[w][i] = ext2[w][i] << (BlW'(NormW) - bl1_r[w]);
        end
        tg2_nxt[w].m[i] = sh2[w][i][NormW-1:0];
      end
      tg2_nxt[w].neg = neg1_r[w];
      tg2_nxt[w].nz  = (bl1_r[w] != '0);
    end
  end

  // integer square root, one result bit per stage
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        trial[w][k] = rs_r[w][k] + (64'd1 << (62 - 2 * k));
        if (xs_r[w][k] >= trial[w][k]) begin
          xs_nxt[w][k] = xs_r[w][k] - trial[w][k];
          rs_nxt[w][k] = (rs_r[w][k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          xs_nxt[w][k] = xs_r[w][k];
          rs_nxt[w][k] = rs_r[w][k] >> 1;
        end
      end
    end
  end

  // component / length, restoring division one bit per stage
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      lenf[w] = tgs_r[w][SqrtSteps].nz ? rs_r[w][SqrtSteps][30:0] : 31'd1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < NormSteps; j++) begin
          td[w][i][j] = {remd_r[w][i][j], 1'b0};
          if (td[w][i][j] >= {1'b0, ntg_r[w][j].dv}) begin
            remd_nxt[w][i][j] = 62'(td[w][i][j] - {1'b0, ntg_r[w][j].dv});
            qd_nxt[w][i][j]   = {qd_r[w][i][j][29:0], 1'b1};
          end else begin
            remd_nxt[w][i][j] = td[w][i][j][61:0];
            qd_nxt[w][i][j]   = {qd_r[w][i][j][29:0], 1'b0};
          end
        end
        qe[w][i] = {1'b0, qd_r[w][i][NormSteps]};
      end
    end
  end

  // rounded cross product and the products of K*K
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff2[a] = p1_r[2 * a] - p1_r[2 * a + 1];
      dmag2[a] = diff2[a][63] ? (~diff2[a] + 1'b1) : diff2[a];
      rsum2[a] = dmag2[a] + RndQ30;
      v2_nxt[a] = diff2[a][63] ? (~rsum2[a][62:30] + 1'b1) : rsum2[a][62:30];
    end
    for (int e = 0; e < 6; e++) begin
      sq5[e] = (e < 3) ? (vv4_r[e] - s4_r) : vv4_r[e];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      qtg6_nxt.v[a] = v5_r[a];
    end
    for (int e = 0; e < 6; e++) begin
      qtg6_nxt.big[e] = ({2'b0, nm5_r[e]} >= dq5_r);
    end
    qtg6_nxt.neg = ng5_r;
    qtg6_nxt.ok  = ok5_r;
    qtg6_nxt.dq  = dq5_r;
  end

  // K*K / (1+c), restoring division one bit per stage
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      for (int j = 0; j < QuotSteps; j++) begin
        tq[e][j] = {remq_r[e][j], 1'b0};
        if (tq[e][j] >= {1'b0, qtg_r[j].dq}) begin
          remq_nxt[e][j] = 66'(tq[e][j] - {1'b0, qtg_r[j].dq});
          qq_nxt[e][j]   = {qq_r[e][j][32:0], 1'b1};
        end else begin
          remq_nxt[e][j] = tq[e][j][65:0];
          qq_nxt[e][j]   = {qq_r[e][j][32:0], 1'b0};
        end
      end
      qr1[e] = (35'(qq_r[e][QuotSteps]) + 35'd1) >> 1;
    end
  end

  // R = I + K + K*K/(1+c), saturated; identity when degenerate
  always_comb begin
    e_sum[0] = OneQ30 + 37'(qs_r[0]);
    e_sum[4] = OneQ30 + 37'(qs_r[1]);
    e_sum[8] = OneQ30 + 37'(qs_r[2]);
    e_sum[1] = 37'(qs_r[3]) - 37'($signed(vf_r[2]));
    e_sum[3] = 37'(qs_r[3]) + 37'($signed(vf_r[2]));
    e_sum[2] = 37'(qs_r[4]) + 37'($signed(vf_r[1]));
    e_sum[6] = 37'(qs_r[4]) - 37'($signed(vf_r[1]));
    e_sum[5] = 37'(qs_r[5]) - 37'($signed(vf_r[0]));
    e_sum[7] = 37'(qs_r[5]) + 37'($signed(vf_r[0]));
    for (int n = 0; n < 9; n++) begin
      if (okf_r) begin
        res_nxt[n] = sat32(e_sum[n]);
      end else begin
        res_nxt[n] = (n % 4 == 0) ? OneOut : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        for (int i = 0; i < 3; i++) begin
          mag0_r[w][i] <= mag0_nxt[w][i];
          neg0_r[w][i] <= vin[w][i][CompW-1];
          mag1_r[w][i] <= mag0_r[w][i];
          p3_r[w][i]   <= 60'(tg2_r[w].m[i]) * 60'(tg2_r[w].m[i]);
        end
        neg1_r[w] <= neg0_r[w];
        bl1_r[w]  <= bl1_nxt[w];
        tg2_r[w]  <= tg2_nxt[w];
        tg3_r[w]  <= tg2_r[w];

        xs_r[w][0]  <= 64'(p3_r[w][0]) + 64'(p3_r[w][1]) + 64'(p3_r[w][2]);
        rs_r[w][0]  <= '0;
        tgs_r[w][0] <= tg3_r[w];
        for (int k = 0; k < SqrtSteps; k++) begin
          xs_r[w][k+1]  <= xs_nxt[w][k];
          rs_r[w][k+1]  <= rs_nxt[w][k];
          tgs_r[w][k+1] <= tgs_r[w][k];
        end

        for (int i = 0; i < 3; i++) begin
          remd_r[w][i][0] <= (62'(tgs_r[w][SqrtSteps].m[i]) << NormW) + 62'(lenf[w] >> 1);
          qd_r[w][i][0]   <= '0;
          for (int j = 0; j < NormSteps; j++) begin
            remd_r[w][i][j+1] <= remd_nxt[w][i][j];
            qd_r[w][i][j+1]   <= qd_nxt[w][i][j];
          end
          u_r[w][i] <= ntg_r[w][NormSteps].neg[i] ? $signed(~qe[w][i] + 1'b1)
                                                  : $signed(qe[w][i]);
        end
        ntg_r[w][0].neg <= tgs_r[w][SqrtSteps].neg;
        ntg_r[w][0].nz  <= tgs_r[w][SqrtSteps].nz;
        ntg_r[w][0].dv  <= 62'(lenf[w]) << 31;
        for (int j = 0; j < NormSteps; j++) begin
          ntg_r[w][j+1] <= ntg_r[w][j];
        end
      end
      oku_r <= ntg_r[0][NormSteps].nz & ntg_r[1][NormSteps].nz;

      p1_r[0] <= u_r[0][1] * u_r[1][2];
      p1_r[1] <= u_r[0][2] * u_r[1][1];
      p1_r[2] <= u_r[0][2] * u_r[1][0];
      p1_r[3] <= u_r[0][0] * u_r[1][2];
      p1_r[4] <= u_r[0][0] * u_r[1][1];
      p1_r[5] <= u_r[0][1] * u_r[1][0];
      p1_r[6] <= u_r[0][0] * u_r[1][0];
      p1_r[7] <= u_r[0][1] * u_r[1][1];
      p1_r[8] <= u_r[0][2] * u_r[1][2];
      ok1_r   <= oku_r;

      v2_r  <= v2_nxt;
      d2_r  <= OneQ60 + p1_r[6] + p1_r[7] + p1_r[8];
      ok2_r <= ok1_r;

      vv3_r[0] <= $signed(v2_r[0]) * $signed(v2_r[0]);
      vv3_r[1] <= $signed(v2_r[1]) * $signed(v2_r[1]);
      vv3_r[2] <= $signed(v2_r[2]) * $signed(v2_r[2]);
      vv3_r[3] <= $signed(v2_r[0]) * $signed(v2_r[1]);
      vv3_r[4] <= $signed(v2_r[0]) * $signed(v2_r[2]);
      vv3_r[5] <= $signed(v2_r[1]) * $signed(v2_r[2]);
      v3_r  <= v2_r;
      d3_r  <= d2_r;
      ok3_r <= ok2_r;

      s4_r  <= vv3_r[0] + vv3_r[1] + vv3_r[2];
      vv4_r <= vv3_r;
      v4_r  <= v3_r;
      d4_r  <= d3_r;
      ok4_r <= ok3_r && (d3_r > 64'sd0);

      for (int e = 0; e < 6; e++) begin
        nm5_r[e] <= sq5[e][63] ? (~sq5[e] + 1'b1) : sq5[e];
        ng5_r[e] <= sq5[e][63];
      end
      // dividing by 8(1+c) lets the divider start with a remainder below the divisor
      dq5_r <= (d4_r > 64'sd0) ? {d4_r[62:0], 3'b0} : '0;
      v5_r  <= v4_r;
      ok5_r <= ok4_r && (s4_r >= SinEpsSq);

      for (int e = 0; e < 6; e++) begin
        remq_r[e][0] <= qtg6_nxt.big[e] ? '0 : {2'b0, nm5_r[e]};
        qq_r[e][0]   <= '0;
        for (int j = 0; j < QuotSteps; j++) begin
          remq_r[e][j+1] <= remq_nxt[e][j];
          qq_r[e][j+1]   <= qq_nxt[e][j];
        end
        // hold large quotients at the cap
        if (qtg_r[QuotSteps].big[e]) begin
          qs_r[e] <= qtg_r[QuotSteps].neg[e] ? -$signed({1'b0, QuotCap})
                                             : $signed({1'b0, QuotCap});
        end else begin
          qs_r[e] <= qtg_r[QuotSteps].neg[e] ? -$signed(qr1[e]) : $signed(qr1[e]);
        end
      end
      qtg_r[0] <= qtg6_nxt;
      for (int j = 0; j < QuotSteps; j++) begin
        qtg_r[j+1] <= qtg_r[j];
      end
      for (int a = 0; a < 3; a++) begin
        vf_r[a] <= qtg_r[QuotSteps].v[a];
      end
      okf_r <= qtg_r[QuotSteps].ok;

      res_r <= res_nxt;
      deg_r <= !okf_r;
    end
  end

  assign out_r00 = res_r[0];
  assign out_r01 = res_r[1];
  assign out_r02 = res_r[2];
  assign out_r10 = res_r[3];
  assign out_r11 = res_r[4];
  assign out_r12 = res_r[5];
  assign out_r20 = res_r[6];
  assign out_r21 = res_r[7];
  assign out_r22 = res_r[8];
  assign out_degenerate = deg_r;

endmodule
